// ----- rtl/bea_pkg.sv -----
// Shared types and constants of the button edge and auto-repeat block.
package bea_pkg;

  localparam int BUTTONS = 16;

  localparam logic [1:0] REG_FIRST_DELAY = 2'd0;
  localparam logic [1:0] REG_INTERVAL    = 2'd1;
  localparam logic [1:0] REG_DEADZONE    = 2'd2;

  localparam logic [15:0] FIRST_DELAY_RESET = 16'd200;
  localparam logic [15:0] INTERVAL_RESET    = 16'd100;
  localparam logic [6:0]  DEADZONE_RESET    = 7'd77;

  localparam logic [2:0] KIND_PRESS   = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_REPEAT  = 3'd2;
  localparam logic [2:0] KIND_STICK_X = 3'd3;
  localparam logic [2:0] KIND_STICK_Y = 3'd4;

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_X    = 5'd0;
  localparam logic [STEP_W-1:0] STEP_Y    = 5'd1;
  localparam logic [STEP_W-1:0] STEP_BTN0 = 5'd2;
  localparam logic [STEP_W-1:0] STEP_END  = 5'd18;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_SCAN,
    BACK_FLUSH
  } back_state_t;

  typedef struct packed {
    logic [15:0] first_repeat_delay;
    logic [15:0] repeat_interval;
    logic [6:0]  stick_deadzone;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         controller;
    logic               report_valid;
    logic [9:0]         remote_buttons;
    logic               extension_present;
    logic [1:0]         extension_buttons;
    logic signed [7:0]  stick_x;
    logic signed [7:0]  stick_y;
    logic [31:0]        now;
  } poll_t;

  typedef struct packed {
    logic [2:0]        event_kind;
    logic [1:0]        controller_out;
    logic [3:0]        button_index;
    logic signed [7:0] stick_value;
    logic              last_event;
  } event_t;

  typedef struct packed {
    logic [1:0]        controller;
    logic [31:0]       now;
    logic [15:0]       cur;
    logic [15:0]       prev;
    logic              sx_chg;
    logic              sy_chg;
    logic signed [7:0] sx;
    logic signed [7:0] sy;
  } desc_t;

endpackage

// ----- rtl/bea_front.sv -----
// Front part: accepts polls, forms the button levels and keeps per-controller levels and sticks.
module bea_front #(
  parameter int CONTROLLERS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bea_pkg::poll_t in_item,
  input  logic [6:0]     stick_deadzone,
  output logic           q_push,
  input  logic           q_ready,
  output bea_pkg::desc_t q_data
);

  localparam int CTL_W = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;

  logic [15:0] levels [CONTROLLERS];
  logic [7:0]  last_x [CONTROLLERS];
  logic [7:0]  last_y [CONTROLLERS];

  logic [CTL_W-1:0]  ci;
  logic              ctl_ok;
  logic [15:0]       cur;
  logic signed [8:0] x9;
  logic signed [8:0] y9;
  logic signed [8:0] dz9;

  assign in_ready = q_ready;
  assign ctl_ok   = (32'(in_item.controller) < CONTROLLERS);
  assign ci       = CTL_W'(in_item.controller);
  assign q_push   = in_valid && in_ready && ctl_ok;

  always_comb begin
    x9  = {in_item.stick_x[7], in_item.stick_x};
    y9  = {in_item.stick_y[7], in_item.stick_y};
    dz9 = {2'b00, stick_deadzone};
    cur = '0;
    if (in_item.report_valid) begin
      cur[9:0] = in_item.remote_buttons;
      if (in_item.extension_present) begin
        cur[11:10] = in_item.extension_buttons;
        cur[12]    = (y9 > dz9);
        cur[13]    = (y9 < -dz9);
        cur[14]    = (x9 < -dz9);
        cur[15]    = (x9 > dz9);
      end
    end
  end

  always_comb begin
    q_data            = '0;
    q_data.controller = in_item.controller;
    q_data.now        = in_item.now;
    q_data.cur        = cur;
    q_data.prev       = levels[ci];
    q_data.sx_chg     = in_item.extension_present && (in_item.stick_x != last_x[ci]);
    q_data.sy_chg     = in_item.extension_present && (in_item.stick_y != last_y[ci]);
    q_data.sx         = in_item.stick_x;
    q_data.sy         = in_item.stick_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CONTROLLERS; i++) begin
        levels[i] <= '0;
        last_x[i] <= '0;
        last_y[i] <= '0;
      end
    end else if (q_push) begin
      levels[ci] <= cur;
      if (in_item.extension_present) begin
        last_x[ci] <= in_item.stick_x;
        last_y[ci] <= in_item.stick_y;
      end
    end
  end

endmodule

// ----- rtl/bea_queue.sv -----
// Two-entry queue of classified polls between the front and back parts.
module bea_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           push_ready,
  input  bea_pkg::desc_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output bea_pkg::desc_t pop_data
);

  bea_pkg::desc_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/bea_back.sv -----
// Back part: steps through a poll's stick axes and buttons; at most one event per cycle.
module bea_back #(
  parameter int CONTROLLERS = 4,
  parameter int TIME_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  bea_pkg::cfg_t    cfg,
  input  logic             q_valid,
  output logic             q_pop,
  input  bea_pkg::desc_t   q_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bea_pkg::event_t  out_item
);

  localparam int CTL_W = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;
  localparam int DEPTH = CONTROLLERS * bea_pkg::BUTTONS;
  localparam int AW    = $clog2(DEPTH);

  logic [TIME_BITS-1:0] mem [DEPTH];

  bea_pkg::back_state_t state;
  bea_pkg::back_state_t state_next;

  bea_pkg::desc_t       d;
  logic [bea_pkg::STEP_W-1:0] a_step;
  logic [bea_pkg::STEP_W-1:0] b_step;
  logic                 b_valid;
  logic [TIME_BITS-1:0] rd_data;
  logic                 pend_valid;
  bea_pkg::event_t      pend;
  bea_pkg::event_t      pend_last;

  logic [CTL_W-1:0]     ci;
  logic [3:0]           a_btn;
  logic [3:0]           b_btn;
  logic [AW-1:0]        addr_a;
  logic [AW-1:0]        addr_b;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] diff;
  logic                 ev_valid;
  bea_pkg::event_t      ev;
  logic                 wr_en;
  logic [TIME_BITS-1:0] wr_data;
  logic                 out_free;
  logic                 b_go;
  logic                 adv;
  logic                 issue;
  logic                 flush_ev;
  logic                 c_lvl;
  logic                 p_lvl;

  assign ci     = CTL_W'(d.controller);
  assign a_btn  = 4'(a_step - bea_pkg::STEP_BTN0);
  assign b_btn  = 4'(b_step - bea_pkg::STEP_BTN0);
  assign addr_a = AW'({ci, a_btn});
  assign addr_b = AW'({ci, b_btn});
  assign now_t  = TIME_BITS'(d.now);
  assign diff   = now_t - rd_data;
  assign c_lvl  = d.cur[b_btn];
  assign p_lvl  = d.prev[b_btn];

  always_comb begin
    ev                = '0;
    ev.controller_out = d.controller;
    ev_valid          = 1'b0;
    wr_en             = 1'b0;
    wr_data           = now_t + TIME_BITS'(cfg.first_repeat_delay);
    if (b_valid) begin
      if (b_step == bea_pkg::STEP_X) begin
        ev_valid       = d.sx_chg;
        ev.event_kind  = bea_pkg::KIND_STICK_X;
        ev.stick_value = d.sx;
      end else if (b_step == bea_pkg::STEP_Y) begin
        ev_valid       = d.sy_chg;
        ev.event_kind  = bea_pkg::KIND_STICK_Y;
        ev.stick_value = d.sy;
      end else if (c_lvl != p_lvl) begin
        ev_valid        = 1'b1;
        ev.event_kind   = c_lvl ? bea_pkg::KIND_PRESS : bea_pkg::KIND_RELEASE;
        ev.button_index = b_btn;
        wr_en           = c_lvl;
      end else if (c_lvl && !diff[TIME_BITS-1]) begin
        ev_valid        = 1'b1;
        ev.event_kind   = bea_pkg::KIND_REPEAT;
        ev.button_index = b_btn;
        wr_en           = 1'b1;
        wr_data         = now_t + TIME_BITS'(cfg.repeat_interval);
      end
    end
  end

  always_comb begin
    pend_last            = pend;
    pend_last.last_event = 1'b1;
  end

  assign out_free = !out_valid || out_ready;
  assign b_go     = b_valid && !(ev_valid && pend_valid && !out_free);
  assign adv      = (state == bea_pkg::BACK_SCAN) && (!b_valid || b_go);
  assign issue    = adv && (a_step != bea_pkg::STEP_END);
  assign flush_ev = (state == bea_pkg::BACK_FLUSH) && pend_valid && out_free;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      bea_pkg::BACK_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          state_next = bea_pkg::BACK_SCAN;
        end
      end
      bea_pkg::BACK_SCAN: begin
        if (adv && (a_step == bea_pkg::STEP_END)) begin
          state_next = bea_pkg::BACK_FLUSH;
        end
      end
      bea_pkg::BACK_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = bea_pkg::BACK_IDLE;
        end
      end
      default: state_next = bea_pkg::BACK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bea_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[addr_a];
    end
    if (b_go && wr_en) begin
      mem[addr_b] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      d <= q_data;
    end
    if (issue) begin
      b_step <= a_step;
    end
    if (b_go && ev_valid) begin
      pend <= ev;
      if (pend_valid) begin
        out_item <= pend;
      end
    end else if (flush_ev) begin
      out_item <= pend_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_step     <= '0;
      b_valid    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if ((b_go && ev_valid && pend_valid) || flush_ev) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        a_step  <= '0;
        b_valid <= 1'b0;
      end else if (issue) begin
        a_step  <= a_step + 1'b1;
        b_valid <= 1'b1;
      end else if (adv) begin
        b_valid <= 1'b0;
      end
      if (b_go && ev_valid) begin
        pend_valid <= 1'b1;
      end else if (flush_ev) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/button_edge_autorepeat_top.sv -----
// Top level of the button edge detector with auto-repeat.
//
//   Channel  Signals                                 Carries
//   in       in_valid, in_ready, in_item             one controller poll
//   out      out_valid, out_ready, out_item          one button or stick event
//   cfg      cfg_we, cfg_index, cfg_data             register writes, no wait
//
// A poll occupies the back part while it is loaded, while two stick axes and 16
// buttons are stepped through the deadline memory's registered read, and while
// the held final event is released. Output stalls pause the stepping.
// A two-entry queue lets the front take polls while the back is busy.
// Reset clears button levels and stored sticks; deadlines need no clearing.
module button_edge_autorepeat_top #(
  parameter int CONTROLLERS = 4,
  parameter int TIME_BITS   = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bea_pkg::poll_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output bea_pkg::event_t out_item,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  bea_pkg::cfg_t  cfg;
  bea_pkg::desc_t push_data;
  bea_pkg::desc_t pop_data;
  logic           push;
  logic           push_ready;
  logic           pop_valid;
  logic           pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_repeat_delay <= bea_pkg::FIRST_DELAY_RESET;
      cfg.repeat_interval    <= bea_pkg::INTERVAL_RESET;
      cfg.stick_deadzone     <= bea_pkg::DEADZONE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bea_pkg::REG_FIRST_DELAY: cfg.first_repeat_delay <= cfg_data;
        bea_pkg::REG_INTERVAL:    cfg.repeat_interval    <= cfg_data;
        bea_pkg::REG_DEADZONE:    cfg.stick_deadzone     <= cfg_data[6:0];
        default:                  cfg                    <= cfg;
      endcase
    end
  end

  bea_front #(
    .CONTROLLERS(CONTROLLERS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .stick_deadzone (cfg.stick_deadzone),
    .q_push         (push),
    .q_ready        (push_ready),
    .q_data         (push_data)
  );

  bea_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  bea_back #(
    .CONTROLLERS(CONTROLLERS),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (pop_valid),
    .q_pop     (pop),
    .q_data    (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
